// ===== sv/jse_pkg.sv =====
// Package with the shared types, character codes and lookup functions of the JSON escaper.
`default_nettype none
package jse_pkg;

    localparam int BODY_MAX = 6;

    typedef logic [7:0] byte_t;
    typedef byte_t [BODY_MAX-1:0] body_t;
    typedef byte_t [2:0] held_t;
    typedef logic [2:0] cnt3_t;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam byte_t CH_QUOTE = 8'h22;
    localparam byte_t CH_BSL   = 8'h5C;
    localparam byte_t CH_BS    = 8'h08;
    localparam byte_t CH_FF    = 8'h0C;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_B     = 8'h62;
    localparam byte_t CH_F     = 8'h66;
    localparam byte_t CH_N     = 8'h6E;
    localparam byte_t CH_R     = 8'h72;
    localparam byte_t CH_T     = 8'h74;
    localparam byte_t CH_U     = 8'h75;
    localparam byte_t CH_ZERO  = 8'h30;

    localparam cnt3_t REP_LAST = 3'd5;

    function automatic byte_t hex_char(input logic [3:0] nib);
        byte_t r;
        if (nib < 4'd10)
        begin
            r = 8'h30 + {4'd0, nib};
        end
        else
        begin
            r = 8'h37 + {4'd0, nib};
        end
        return r;
    endfunction

    // Characters of the six-byte replacement escape, by position.
    function automatic byte_t rep_char(input cnt3_t idx);
        byte_t r;
        case (idx)
            3'd0:    r = CH_BSL;
            3'd1:    r = CH_U;
            3'd2:    r = 8'h46;
            3'd3:    r = 8'h46;
            3'd4:    r = 8'h46;
            default: r = 8'h44;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/jse_if.sv =====
// Stream interfaces for the input bytes and the escaped output text.
`default_nettype none
interface jse_in_if;
    logic           valid;
    logic           ready;
    logic           kind;
    jse_pkg::byte_t data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface jse_out_if;
    logic           valid;
    logic           ready;
    jse_pkg::byte_t out_byte;
    logic           last_of_run;
    logic           closes_string;

    modport source (output valid, output out_byte, output last_of_run,
                    output closes_string, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input closes_string, output ready);
endinterface
`default_nettype wire

// ===== sv/json_string_escaper_utf8.sv =====
// JSON string escaper with UTF-8 validation: the top level.
//
// The byte_in channel takes one beat per string byte (kind low) and one beat
// to end the string (kind high). The text_out channel gives one beat per byte
// of the quoted, escaped text; last_of_run marks the final beat caused by an
// input beat and closes_string marks the closing quote.
// An accepted beat is decoded at once into a run descriptor register; an
// emitter steps through it and loads one byte a cycle into the output
// register. The first byte of a run passes through the descriptor register
// and then the output register before it is visible on text_out. byte_in
// is ready again in the cycle in which the last byte of the run is loaded,
// so runs follow each other with no gap. A beat that only holds a lead or
// continuation byte makes no output unless it opens the string.
// Throughput is one output byte per cycle, set by the single output register.
// Reset empties the descriptor and the output register, drops any held
// partial sequence and marks no string as open.
// When the receiver stalls, the output register holds its beat, the emitter
// waits and byte_in drops ready until the current run is done.
`default_nettype none
module json_string_escaper_utf8 (
    input  wire logic clk,
    input  wire logic rst_n,
    jse_in_if.sink    byte_in,
    jse_out_if.source text_out
);
    import jse_pkg::*;

    // Decoder state.
    held_t       held_reg, held_next;
    logic [1:0]  cnt_reg, cnt_next;
    cnt3_t       need_reg, need_next;
    logic        str_open_reg, str_open_next;

    // Run descriptor.
    logic        job_valid_reg;
    logic        open_reg;
    cnt3_t       reps_reg;
    cnt3_t       rep_idx_reg;
    body_t       body_reg;
    cnt3_t       body_len_reg;
    cnt3_t       body_idx_reg;
    logic        close_reg;

    // Output register.
    logic        out_valid_reg;
    byte_t       out_byte_reg;
    logic        out_last_reg;
    logic        out_close_reg;

    // Descriptor of the beat being accepted.
    logic        a_open;
    cnt3_t       a_reps;
    body_t       a_body;
    cnt3_t       a_len;
    logic        a_close;
    logic        a_nonempty;
    logic        do_fresh;
    logic        seq_ok;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    byte_t       c;

    // Emitter.
    byte_t       e_byte;
    logic        e_closes;
    logic        e_open_next;
    cnt3_t       e_reps_next;
    cnt3_t       e_rep_idx_next;
    cnt3_t       e_body_idx_next;
    logic        e_close_next;
    logic        e_last;

    logic        load;
    logic        advance;
    logic        accept;

    assign load    = !out_valid_reg || text_out.ready;
    assign advance = job_valid_reg && load;
    assign byte_in.ready = !job_valid_reg || (load && e_last);
    assign accept  = byte_in.valid && byte_in.ready;
    assign c       = byte_in.data_byte;

    assign cp2 = {held_reg[0][4:0], c[5:0]};
    assign cp3 = {held_reg[0][3:0], held_reg[1][5:0], c[5:0]};
    assign cp4 = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0], c[5:0]};

    always_comb
    begin
        case (need_reg)
            3'd2:    seq_ok = (cp2 >= 11'h080);
            3'd3:    seq_ok = (cp3 >= 16'h0800) && !(cp3 >= 16'hD800 && cp3 <= 16'hDFFF);
            default: seq_ok = (cp4 >= 21'h10000) && (cp4 <= 21'h10FFFF);
        endcase
    end

    always_comb
    begin
        held_next     = held_reg;
        cnt_next      = cnt_reg;
        need_next     = need_reg;
        str_open_next = str_open_reg;
        a_open        = !str_open_reg;
        a_reps        = '0;
        a_body        = '0;
        a_len         = '0;
        a_close       = 1'b0;
        do_fresh      = 1'b0;

        if (byte_in.kind == KIND_END)
        begin
            a_reps        = {1'b0, cnt_reg};
            a_close       = 1'b1;
            cnt_next      = '0;
            need_next     = '0;
            str_open_next = 1'b0;
        end
        else
        begin
            str_open_next = 1'b1;
            if (need_reg != '0)
            begin
                if (c[7:6] == 2'b10)
                begin
                    if ((({1'b0, cnt_reg} + 3'd1) >= need_reg) || (cnt_reg == 2'd3))
                    begin
                        cnt_next  = '0;
                        need_next = '0;
                        if (seq_ok)
                        begin
                            a_len     = need_reg;
                            a_body[0] = held_reg[0];
                            case (need_reg)
                                3'd2:
                                begin
                                    a_body[1] = c;
                                end
                                3'd3:
                                begin
                                    a_body[1] = held_reg[1];
                                    a_body[2] = c;
                                end
                                default:
                                begin
                                    a_body[1] = held_reg[1];
                                    a_body[2] = held_reg[2];
                                    a_body[3] = c;
                                end
                            endcase
                        end
                        else
                        begin
                            a_reps = need_reg;
                        end
                    end
                    else
                    begin
                        held_next[cnt_reg] = c;
                        cnt_next           = cnt_reg + 2'd1;
                    end
                end
                else
                begin
                    a_reps    = {1'b0, cnt_reg};
                    cnt_next  = '0;
                    need_next = '0;
                    do_fresh  = 1'b1;
                end
            end
            else
            begin
                do_fresh = 1'b1;
            end
        end

        if (do_fresh)
        begin
            case (c) inside
                CH_QUOTE:
                begin
                    a_body[0] = CH_BSL; a_body[1] = CH_QUOTE; a_len = 3'd2;
                end
                CH_BSL:
                begin
                    a_body[0] = CH_BSL; a_body[1] = CH_BSL; a_len = 3'd2;
                end
                CH_BS:
                begin
                    a_body[0] = CH_BSL; a_body[1] = CH_B; a_len = 3'd2;
                end
                CH_FF:
                begin
                    a_body[0] = CH_BSL; a_body[1] = CH_F; a_len = 3'd2;
                end
                CH_LF:
                begin
                    a_body[0] = CH_BSL; a_body[1] = CH_N; a_len = 3'd2;
                end
                CH_CR:
                begin
                    a_body[0] = CH_BSL; a_body[1] = CH_R; a_len = 3'd2;
                end
                CH_TAB:
                begin
                    a_body[0] = CH_BSL; a_body[1] = CH_T; a_len = 3'd2;
                end
                [8'h00:8'h1F]:
                begin
                    a_body[0] = CH_BSL;
                    a_body[1] = CH_U;
                    a_body[2] = CH_ZERO;
                    a_body[3] = CH_ZERO;
                    a_body[4] = hex_char(c[7:4]);
                    a_body[5] = hex_char(c[3:0]);
                    a_len     = 3'd6;
                end
                [8'h20:8'h7F]:
                begin
                    a_body[0] = c; a_len = 3'd1;
                end
                [8'hC0:8'hDF]:
                begin
                    held_next[0] = c; cnt_next = 2'd1; need_next = 3'd2;
                end
                [8'hE0:8'hEF]:
                begin
                    held_next[0] = c; cnt_next = 2'd1; need_next = 3'd3;
                end
                [8'hF0:8'hF7]:
                begin
                    held_next[0] = c; cnt_next = 2'd1; need_next = 3'd4;
                end
                default:
                begin
                    a_reps = a_reps + 3'd1;
                end
            endcase
        end
    end

    assign a_nonempty = a_open || (a_reps != '0) || (a_len != '0) || a_close;

    always_comb
    begin
        e_open_next     = open_reg;
        e_reps_next     = reps_reg;
        e_rep_idx_next  = rep_idx_reg;
        e_body_idx_next = body_idx_reg;
        e_close_next    = close_reg;
        e_closes        = 1'b0;
        if (open_reg)
        begin
            e_byte      = CH_QUOTE;
            e_open_next = 1'b0;
        end
        else if (reps_reg != '0)
        begin
            e_byte = rep_char(rep_idx_reg);
            if (rep_idx_reg == REP_LAST)
            begin
                e_rep_idx_next = '0;
                e_reps_next    = reps_reg - 3'd1;
            end
            else
            begin
                e_rep_idx_next = rep_idx_reg + 3'd1;
            end
        end
        else if (body_idx_reg < body_len_reg)
        begin
            e_byte          = body_reg[body_idx_reg];
            e_body_idx_next = body_idx_reg + 3'd1;
        end
        else
        begin
            e_byte       = CH_QUOTE;
            e_closes     = 1'b1;
            e_close_next = 1'b0;
        end
        e_last = !e_open_next && (e_reps_next == '0) &&
                 (e_body_idx_next >= body_len_reg) && !e_close_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            need_reg     <= '0;
            str_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            cnt_reg      <= cnt_next;
            need_reg     <= need_next;
            str_open_reg <= str_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            open_reg      <= 1'b0;
            reps_reg      <= '0;
            rep_idx_reg   <= '0;
            body_len_reg  <= '0;
            body_idx_reg  <= '0;
            close_reg     <= 1'b0;
        end
        else if (accept)
        begin
            job_valid_reg <= a_nonempty;
            open_reg      <= a_open;
            reps_reg      <= a_reps;
            rep_idx_reg   <= '0;
            body_len_reg  <= a_len;
            body_idx_reg  <= '0;
            close_reg     <= a_close;
        end
        else if (advance)
        begin
            job_valid_reg <= !e_last;
            open_reg      <= e_open_next;
            reps_reg      <= e_reps_next;
            rep_idx_reg   <= e_rep_idx_next;
            body_idx_reg  <= e_body_idx_next;
            close_reg     <= e_close_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            body_reg <= a_body;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= job_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= e_byte;
            out_last_reg  <= e_last;
            out_close_reg <= e_closes;
        end
    end

    assign text_out.valid         = out_valid_reg;
    assign text_out.out_byte      = out_byte_reg;
    assign text_out.last_of_run   = out_last_reg;
    assign text_out.closes_string = out_close_reg;

endmodule
`default_nettype wire

// ===== sim/escape_text_checker.sv =====
// Checker that predicts the escaped JSON text from the input beats and compares every output beat.
module escape_text_checker (
    input  logic      clk,
    input  logic      rst_n,
    jse_in_if         byte_in,
    jse_out_if        text_out,
    output int        mismatches,
    output int        pending,
    output int        beats_in,
    output int        beats_out
);
    import jse_pkg::*;

    typedef struct packed {
        byte_t ch;
        logic  last;
        logic  closes;
    } text_beat_t;

    text_beat_t  expected_text[$];
    text_beat_t  run_text[$];
    byte_t       lead_hold[3];
    logic [1:0]  hold_count;
    logic [2:0]  seq_length;
    logic        quote_open;

    function automatic void put_char(byte_t ch, logic closes);
        text_beat_t b;
        b.ch     = ch;
        b.last   = 1'b0;
        b.closes = closes;
        run_text.push_back(b);
    endfunction

    function automatic void put_pair(byte_t ch);
        put_char(CH_BSL, 1'b0);
        put_char(ch, 1'b0);
    endfunction

    function automatic void put_fffd();
        put_char(CH_BSL, 1'b0);
        put_char(CH_U, 1'b0);
        put_char("F", 1'b0);
        put_char("F", 1'b0);
        put_char("F", 1'b0);
        put_char("D", 1'b0);
    endfunction

    function automatic byte_t hex_digit(logic [3:0] v);
        if (v < 4'd10)
        begin
            return CH_ZERO + v;
        end
        return "A" + v - 8'd10;
    endfunction

    function automatic void drop_held();
        lead_hold[0] = 8'h00;
        lead_hold[1] = 8'h00;
        lead_hold[2] = 8'h00;
        hold_count   = 2'd0;
        seq_length   = 3'd0;
    endfunction

    function automatic void flush_held();
        int k;
        for (k = 0; k < hold_count; k++)
        begin
            put_fffd();
        end
        drop_held();
    endfunction

    function automatic void escape_fresh(byte_t c);
        case (c)
            CH_QUOTE: put_pair(CH_QUOTE);
            CH_BSL:   put_pair(CH_BSL);
            CH_BS:    put_pair(CH_B);
            CH_FF:    put_pair(CH_F);
            CH_LF:    put_pair(CH_N);
            CH_CR:    put_pair(CH_R);
            CH_TAB:   put_pair(CH_T);
            default:
            begin
                if (c < 8'h20)
                begin
                    put_pair(CH_U);
                    put_char(CH_ZERO, 1'b0);
                    put_char(CH_ZERO, 1'b0);
                    put_char(hex_digit(c[7:4]), 1'b0);
                    put_char(hex_digit(c[3:0]), 1'b0);
                end
                else if (c < 8'h80)
                begin
                    put_char(c, 1'b0);
                end
                else if (c[7:5] == 3'b110 || c[7:4] == 4'b1110 || c[7:3] == 5'b11110)
                begin
                    seq_length   = (c[7:5] == 3'b110) ? 3'd2 :
                                   (c[7:4] == 4'b1110) ? 3'd3 : 3'd4;
                    lead_hold[0] = c;
                    hold_count   = 2'd1;
                end
                else
                begin
                    put_fffd();
                end
            end
        endcase
    endfunction

    function automatic void close_sequence(byte_t c);
        byte_t       seq [4];
        logic [20:0] cp;
        logic        ok;
        int          n;
        int          k;
        n = seq_length;
        for (k = 0; k < 3; k++)
        begin
            seq[k] = lead_hold[k];
        end
        seq[n-1] = c;
        case (n)
            2:       cp = {16'd0, seq[0][4:0]};
            3:       cp = {17'd0, seq[0][3:0]};
            default: cp = {18'd0, seq[0][2:0]};
        endcase
        for (k = 1; k < n; k++)
        begin
            cp = {cp[14:0], seq[k][5:0]};
        end
        ok = (cp <= 21'h10FFFF) && !(cp >= 21'h00D800 && cp <= 21'h00DFFF);
        if ((n == 2 && cp < 21'h80) || (n == 3 && cp < 21'h800) ||
            (n == 4 && cp < 21'h10000))
        begin
            ok = 1'b0;
        end
        for (k = 0; k < n; k++)
        begin
            if (ok)
            begin
                put_char(seq[k], 1'b0);
            end
            else
            begin
                put_fffd();
            end
        end
        drop_held();
    endfunction

    function automatic void escape_item(logic kind, byte_t c);
        run_text.delete();
        if (!quote_open)
        begin
            put_char(CH_QUOTE, 1'b0);
            quote_open = 1'b1;
        end
        if (kind == KIND_END)
        begin
            flush_held();
            put_char(CH_QUOTE, 1'b1);
            quote_open = 1'b0;
        end
        else if (seq_length != 3'd0)
        begin
            if (c[7:6] == 2'b10)
            begin
                if (hold_count + 3'd1 >= seq_length || hold_count >= 2'd3)
                begin
                    close_sequence(c);
                end
                else
                begin
                    lead_hold[hold_count] = c;
                    hold_count = hold_count + 2'd1;
                end
            end
            else
            begin
                flush_held();
                escape_fresh(c);
            end
        end
        else
        begin
            escape_fresh(c);
        end
        if (run_text.size() > 0)
        begin
            run_text[run_text.size()-1].last = 1'b1;
        end
        foreach (run_text[i])
        begin
            expected_text.push_back(run_text[i]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_beat_t want;
        if (!rst_n)
        begin
            drop_held();
            quote_open = 1'b0;
            expected_text.delete();
            mismatches = 0;
            pending    = 0;
            beats_in   = 0;
            beats_out  = 0;
        end
        else
        begin
            if (byte_in.valid && byte_in.ready)
            begin
                escape_item(byte_in.kind, byte_in.data_byte);
                beats_in++;
            end
            if (text_out.valid && text_out.ready)
            begin
                beats_out++;
                if (expected_text.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("ERROR: beat %0d byte %02h last %0b close %0b not expected",
                                 beats_out, text_out.out_byte, text_out.last_of_run,
                                 text_out.closes_string);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text_out.out_byte !== want.ch || text_out.last_of_run !== want.last ||
                        text_out.closes_string !== want.closes)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("ERROR: beat %0d want %02h/%0b/%0b got %02h/%0b/%0b",
                                     beats_out, want.ch, want.last, want.closes,
                                     text_out.out_byte, text_out.last_of_run,
                                     text_out.closes_string);
                        end
                        mismatches++;
                    end
                end
            end
            pending = expected_text.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Top of the JSON escaper simulation: clock, reset, string stimulus, output stalls and the verdict.
module testbench;
    import jse_pkg::*;

    localparam int ITEM_TARGET = 460;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic  kind;
        byte_t data;
    } in_beat_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   beats_in;
    int   beats_out;
    int   burst_left;
    int   gap_odds;
    int   ready_style;
    int   items_sent;
    int   strings_sent;
    int   cycles;

    in_beat_t plan[$];

    jse_in_if  byte_in ();
    jse_out_if text_out ();

    json_string_escaper_utf8 i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .text_out (text_out)
    );

    escape_text_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .text_out   (text_out),
        .mismatches (mismatches),
        .pending    (pending),
        .beats_in   (beats_in),
        .beats_out  (beats_out)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d beats pending.", cycles, pending);
        $display("Mismatches found");
        $finish;
    end

    // The receiver stall pattern changes with ready_style.
    initial
    begin
        int stall_left;
        stall_left     = 0;
        text_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            case (ready_style)
                0: text_out.ready <= 1'b1;
                1: text_out.ready <= ($urandom_range(0, 3) != 0);
                2: text_out.ready <= cycles[1] | cycles[2];
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        text_out.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 9) == 0)
                    begin
                        stall_left = $urandom_range(1, 12);
                        text_out.ready <= 1'b0;
                    end
                    else
                    begin
                        text_out.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    function automatic void queue_byte(byte_t b);
        in_beat_t x;
        x.kind = KIND_BYTE;
        x.data = b;
        plan.push_back(x);
    endfunction

    function automatic void queue_end();
        in_beat_t x;
        x.kind = KIND_END;
        x.data = byte_t'($urandom_range(0, 255));
        plan.push_back(x);
    endfunction

    // One piece of string content: mostly well-formed text, some broken sequences and noise.
    function automatic void add_piece();
        int          pick;
        int          n;
        int          cnt;
        int          k;
        logic [20:0] cp;
        byte_t       lead;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            queue_byte(byte_t'($urandom_range(8'h20, 8'h7E)));
        end
        else if (pick < 40)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                queue_byte($urandom_range(0, 1) ? CH_QUOTE : CH_BSL);
            end
            else
            begin
                queue_byte(byte_t'($urandom_range(0, 31)));
            end
        end
        else if (pick < 65)
        begin
            n = $urandom_range(2, 4);
            case (n)
                2:
                begin
                    cp = 21'($urandom_range(32'h80, 32'h7FF));
                    queue_byte({3'b110, cp[10:6]});
                end
                3:
                begin
                    cp = 21'($urandom_range(32'h800, 32'hF7FF));
                    if (cp >= 21'hD800)
                    begin
                        cp = cp + 21'h800;
                    end
                    queue_byte({4'b1110, cp[15:12]});
                    queue_byte({2'b10, cp[11:6]});
                end
                default:
                begin
                    cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
                    queue_byte({5'b11110, cp[20:18]});
                    queue_byte({2'b10, cp[17:12]});
                    queue_byte({2'b10, cp[11:6]});
                end
            endcase
            queue_byte({2'b10, cp[5:0]});
        end
        else if (pick < 90)
        begin
            lead = byte_t'($urandom_range(8'hC0, 8'hF7));
            n = lead[5] ? (lead[4] ? 4 : 3) : 2;
            cnt = (pick < 80) ? n - 1 : $urandom_range(0, n - 2);
            queue_byte(lead);
            for (k = 0; k < cnt; k++)
            begin
                queue_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
            end
        end
        else
        begin
            queue_byte(byte_t'($urandom_range(0, 255)));
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(in_beat_t x);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_odds != 0 && $urandom_range(0, 3) < gap_odds)
            begin
                byte_in.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        byte_in.valid     <= 1'b1;
        byte_in.kind      <= x.kind;
        byte_in.data_byte <= x.data;
        @(posedge clk);
        while (!byte_in.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_plan();
        while (plan.size() > 0)
        begin
            send_beat(plan.pop_front());
        end
    endtask

    initial
    begin
        int directed_bytes[];
        int npieces;
        int k;
        directed_bytes = '{-1, 'h00, 'h22, 'h5C, 'h08, 'h0C, 'h0A, 'h0D, 'h09, 'h41,
                           -1, 'hC3, 'hA9, 'hF4, 'h8F, 'hBF, 'hBF, 'hC0, 'h80,
                           'hED, 'hA0, 'h80, 'h80, 'hFF, 'hE2, 'h41, 'hF0, 'h90, -1};
        byte_in.valid     = 1'b0;
        byte_in.kind      = KIND_BYTE;
        byte_in.data_byte = 8'h00;
        rst_n             = 1'b0;
        burst_left        = 0;
        gap_odds          = 0;
        ready_style       = 0;
        items_sent        = 0;
        strings_sent      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_bytes[i])
        begin
            if (directed_bytes[i] < 0)
            begin
                queue_end();
            end
            else
            begin
                queue_byte(byte_t'(directed_bytes[i]));
            end
        end
        gap_odds    = 2;
        ready_style = 1;
        send_plan();

        while (items_sent < ITEM_TARGET)
        begin
            if (strings_sent % 8 == 0)
            begin
                gap_odds    = $urandom_range(0, 3);
                ready_style = $urandom_range(0, 3);
            end
            npieces = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
            for (k = 0; k < npieces; k++)
            begin
                add_piece();
            end
            queue_end();
            send_plan();
            strings_sent++;
        end
        byte_in.valid <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);

        $display("Sent %0d input beats in %0d random strings after the directed cases.",
                 beats_in, strings_sent);
        $display("Checked %0d output beats under varied sender gaps and receiver stalls.",
                 beats_out);
        if (mismatches == 0 && pending == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
